// ===== rtl/nvqe_pkg.sv =====
// Shared types, constants and helpers for the I/O queue engine.
// Used by every module of the block; depends on nothing else.

package nvqe_pkg;

    // Queue-pair configuration.
    localparam int QUEUE_DEPTH      = 64;
    localparam int MAX_LIST_ENTRIES = 32;
    localparam int IO_QUEUE_ID      = 1;

    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(MAX_LIST_ENTRIES + 1);

    // Shared adder width: byte counts are 32 bits wide, plus carry and sign.
    localparam int ALU_W = 34;
    localparam int REM_W = ALU_W - 1;
    localparam int ENT_W = ALU_W - 12;

    localparam int DB_W  = 19;
    localparam int DBV_W = 6;

    localparam logic [12:0]      PAGE_BYTES    = 13'h1000;
    localparam logic [ALU_W-1:0] PAGE_ROUND    = ALU_W'(32'h0000_0FFF);
    localparam logic [ALU_W-1:0] PAGE_STEP     = ALU_W'(32'h0000_1000);
    localparam logic [DB_W-1:0]  DOORBELL_BASE = DB_W'(32'h0000_1000);
    localparam logic [10:0]      CODE_MASK     = 11'h7FF;

    localparam logic [4:0] SQ_DB_SLOT = 5'(2 * IO_QUEUE_ID);
    localparam logic [4:0] CQ_DB_SLOT = 5'(2 * IO_QUEUE_ID + 1);

    // Configuration register indexes.
    localparam logic [7:0] REG_BLOCK_ENABLED = 8'd0;
    localparam logic [7:0] REG_SECTOR_SHIFT  = 8'd1;
    localparam logic [7:0] REG_LIST_BASE     = 8'd2;
    localparam logic [7:0] REG_DB_STRIDE     = 8'd3;

    typedef enum logic [2:0] {
        KIND_CMD       = 3'd0,
        KIND_LIST      = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_NOT_READY = 3'd3,
        KIND_REJECT    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM,
        ST_ROUND,
        ST_CHECK,
        ST_NEXT,
        ST_LIST,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        req_type;
        logic [63:0] start_lba;
        logic [16:0] block_count;
        logic [31:0] buffer_address;
        logic [7:0]  opcode;
        logic [15:0] completion_status;
    } in_word_t;

    typedef struct packed {
        logic [2:0]       result_kind;
        logic [31:0]      command_word0;
        logic [31:0]      prp_first;
        logic [31:0]      prp_second;
        logic [63:0]      cmd_lba;
        logic [15:0]      cmd_count_minus_one;
        logic [31:0]      list_entry;
        logic [DB_W-1:0]  doorbell_offset;
        logic [DBV_W-1:0] doorbell_value;
        logic             status_ok;
        logic             last;
    } out_word_t;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             neg;
        logic             zero;
    } alu_rsp_t;

    // Doorbell register offset for a slot, wrapping at the field width.
    function automatic logic [DB_W-1:0] doorbell_at(input logic [4:0] slot,
                                                    input logic [3:0] stride_shift);
        logic [DB_W-1:0] step;
        step = DB_W'(slot) << ({1'b0, stride_shift} + 5'd2);
        return DOORBELL_BASE + step;
    endfunction

endpackage

// ===== rtl/nvqe_alu.sv =====
// Shared add/subtract unit with sign and zero flags.
// Depends on nvqe_pkg for the request and response types.

module nvqe_alu import nvqe_pkg::*; (
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W-1:0] sum;

    always_comb begin
        sum      = req.sub ? (req.a - req.b) : (req.a + req.b);
        rsp.sum  = sum;
        rsp.neg  = sum[ALU_W-1];
        rsp.zero = (sum == '0);
    end

endmodule

// ===== rtl/nvme_io_queue_engine_unit.sv =====
// Host-side engine for one I/O submission/completion queue pair with PRP pointers.
// Depends on nvqe_pkg and nvqe_alu.

// A completion word, or a submit while the block is disabled, passes from the
// idle state to the emit state, which loads its single result word into the
// output register once the output is free. An accepted submit first uses the
// shared 34-bit adder for the bytes past the first page. If any bytes remain,
// a second step rounds them up to whole pages. A third step then either forms
// the second page pointer or checks the list size against the limit. List
// entries follow at one cycle each while the output is free (up to 32), and
// the command word comes last. If the transfer fits in the first page, the
// command word is loaded from the emit state straight after the first step.
// If a second page pointer is needed, it is loaded after the third step, and a
// list that is too long is rejected after the check. Otherwise the list entries
// come between the check and the command word. Every step goes through that
// one adder, which sets the pace. The input side is ready again once the final
// result word is in the output register, so a result that waits to be taken
// does not hold back the next input word. Configuration writes are always ready.

module nvme_io_queue_engine_unit import nvqe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    state_t state_reg, state_next;

    logic        enabled_reg;
    logic [3:0]  sector_shift_reg;
    logic [31:0] list_base_reg;
    logic [3:0]  stride_reg;

    logic [15:0]       cmd_id_reg, cmd_id_next;
    logic [QIDX_W-1:0] tail_reg, tail_next;
    logic [QIDX_W-1:0] head_reg, head_next;
    logic              phase_reg, phase_next;

    in_word_t          item_reg, item_next;
    kind_t             kind_reg, kind_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ENT_W-1:0]  ent_reg, ent_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       page_reg, page_next;
    logic [31:0]       prp2_reg, prp2_next;

    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic [31:0]       nbytes;
    logic [12:0]       first_rem;
    logic [QIDX_W-1:0] tail_inc, head_inc;
    logic              out_free;
    logic              accept;

    nvqe_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign nbytes    = {15'd0, item_reg.block_count} << sector_shift_reg;
    assign first_rem = PAGE_BYTES - {1'b0, item_reg.buffer_address[11:0]};
    assign tail_inc  = (tail_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc  = (head_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Operand selection for the shared adder.
    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            ST_REM: begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(nbytes);
                alu_req.b   = ALU_W'(first_rem);
            end
            ST_ROUND: begin
                alu_req.a = ALU_W'(rem_reg);
                alu_req.b = PAGE_ROUND;
            end
            ST_CHECK: begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(MAX_LIST_ENTRIES);
                alu_req.b   = ALU_W'(ent_reg);
            end
            ST_NEXT, ST_LIST: begin
                alu_req.a = ALU_W'(page_reg);
                alu_req.b = PAGE_STEP;
            end
            ST_IDLE, ST_EMIT: begin
                alu_req = '0;
            end
            default: alu_req = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmd_id_reg  <= 16'd1;
            tail_reg    <= '0;
            head_reg    <= '0;
            phase_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmd_id_reg  <= cmd_id_next;
            tail_reg    <= tail_next;
            head_reg    <= head_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg      <= 1'b0;
            sector_shift_reg <= 4'd9;
            list_base_reg    <= '0;
            stride_reg       <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BLOCK_ENABLED: enabled_reg      <= cfg_data[0];
                REG_SECTOR_SHIFT:  sector_shift_reg <= cfg_data[3:0];
                REG_LIST_BASE:     list_base_reg    <= cfg_data;
                REG_DB_STRIDE:     stride_reg       <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        kind_reg   <= kind_next;
        rem_reg    <= rem_next;
        ent_reg    <= ent_next;
        cnt_reg    <= cnt_next;
        page_reg   <= page_next;
        prp2_reg   <= prp2_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        cmd_id_next  = cmd_id_reg;
        tail_next    = tail_reg;
        head_next    = head_reg;
        phase_next   = phase_reg;
        item_next    = item_reg;
        kind_next    = kind_reg;
        rem_next     = rem_reg;
        ent_next     = ent_reg;
        cnt_next     = cnt_reg;
        page_next    = page_reg;
        prp2_next    = prp2_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_next  = s_data;
                    page_next  = {s_data.buffer_address[31:12], 12'd0};
                    prp2_next  = '0;
                    state_next = ST_EMIT;
                    if (s_data.req_type) begin
                        kind_next = (s_data.completion_status[0] == phase_reg)
                                    ? KIND_DONE : KIND_NOT_READY;
                    end else if (!enabled_reg) begin
                        kind_next = KIND_REJECT;
                    end else begin
                        kind_next  = KIND_CMD;
                        state_next = ST_REM;
                    end
                end
            end
            ST_REM: begin
                // Bytes beyond what the first page can hold.
                rem_next = alu_rsp.sum[REM_W-1:0];
                if (alu_rsp.neg || alu_rsp.zero) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                ent_next = alu_rsp.sum[ALU_W-1:12];
                if (alu_rsp.sum[ALU_W-1:13] == '0) begin
                    state_next = ST_NEXT;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (alu_rsp.neg) begin
                    kind_next  = KIND_REJECT;
                    state_next = ST_EMIT;
                end else begin
                    cnt_next   = ent_reg[CNT_W-1:0];
                    prp2_next  = list_base_reg;
                    state_next = ST_LIST;
                end
            end
            ST_NEXT: begin
                prp2_next  = alu_rsp.sum[31:0];
                state_next = ST_EMIT;
            end
            ST_LIST: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next            = '0;
                    m_data_next.result_kind = KIND_LIST;
                    m_data_next.list_entry = alu_rsp.sum[31:0];
                    page_next              = alu_rsp.sum[31:0];
                    cnt_next               = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next             = '0;
                    m_data_next.result_kind = kind_reg;
                    m_data_next.last        = 1'b1;
                    state_next              = ST_IDLE;
                    unique case (kind_reg)
                        KIND_CMD: begin
                            m_data_next.command_word0 =
                                {cmd_id_reg, 8'd0, item_reg.opcode};
                            m_data_next.prp_first           = item_reg.buffer_address;
                            m_data_next.prp_second          = prp2_reg;
                            m_data_next.cmd_lba             = item_reg.start_lba;
                            m_data_next.cmd_count_minus_one =
                                item_reg.block_count[15:0] - 16'd1;
                            m_data_next.doorbell_offset = doorbell_at(SQ_DB_SLOT, stride_reg);
                            m_data_next.doorbell_value  = DBV_W'(tail_inc);
                            cmd_id_next = cmd_id_reg + 16'd1;
                            tail_next   = tail_inc;
                        end
                        KIND_DONE: begin
                            m_data_next.doorbell_offset = doorbell_at(CQ_DB_SLOT, stride_reg);
                            m_data_next.doorbell_value  = DBV_W'(head_inc);
                            m_data_next.status_ok =
                                ((item_reg.completion_status[11:1] & CODE_MASK) == '0);
                            head_next = head_inc;
                            // The expected phase flips each time the head wraps.
                            if (head_inc == '0) begin
                                phase_next = !phase_reg;
                            end
                        end
                        KIND_LIST, KIND_NOT_READY, KIND_REJECT: ;
                        default: ;
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_list_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == KIND_LIST) |-> !m_data.last)
        else $error("list entry word marked as last");

    a_list_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIST) |-> (cnt_reg != '0))
        else $error("list emission with no entries left");

    a_tail_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && kind_reg == KIND_CMD)
        |=> (tail_reg != $past(tail_reg)) && (cmd_id_reg == $past(cmd_id_reg) + 16'd1))
        else $error("command issued without advancing tail and command id");

    a_phase_on_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && phase_reg != $past(phase_reg)) |-> (head_reg == '0))
        else $error("phase flipped without head wrap");

endmodule
